### hw/rtl/rm_pkg.sv
// rm_pkg: shared types and constants for the running median block.
// Holds the cell operation codes and the structs passed between the
// top level, the chains and the cells. No dependencies.
package rm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 11;

  // Operation applied to every cell of one chain in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,        // keep contents
    OP_INSERT,      // sorted insert of the broadcast sample
    OP_PUSH,        // push a new head, shift everything one cell down
    OP_POP_INSERT   // drop the head and insert the broadcast sample
  } cell_op_t;

  typedef struct packed {
    cell_op_t                    op;
    logic signed [SAMPLE_W-1:0]  sample;
    logic signed [SAMPLE_W-1:0]  push_val;
  } chain_ctrl_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  value;
    logic                        ahead;
  } cell_link_t;

endpackage

### hw/rtl/rm_if.sv
// rm_if: valid/ready channel interfaces for the running median block.
// Depends on rm_pkg for the field widths.
interface rm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [rm_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rm_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [rm_pkg::MEDIAN_W-1:0]  median_doubled;
  logic        [rm_pkg::COUNT_W-1:0]   sample_count;
  logic                                dropped;

  modport source (output valid, output median_doubled, output sample_count,
                  output dropped, input ready);
  modport sink   (input valid, input median_doubled, input sample_count,
                  input dropped, output ready);
endinterface

### hw/rtl/running_median.sv
//  channel  | dir | interface     | payload
//  ---------+-----+---------------+-------------------------------------------
//  samples  | in  | rm_sample_if  | sample (32 signed)
//  results  | out | rm_result_if  | median_doubled (33 signed), sample_count
//           |     |               | (11), dropped (1)
//
// One transaction in, one transaction out. A sample is taken every cycle while
// results drains; the result is registered (the chains update on the accepting
// edge, then the median sum loads the output register once the output slot is
// free).
// The cell chains update all together: the sample is broadcast to every cell
// and each cell decides locally from its neighbors, so the rate is set by that
// broadcast compare plus the head sum, not by CAPACITY.
// Reset (rst, synchronous) empties the store; no clearing pass is needed since
// cell contents are only read below the held count.
// A stalled results channel holds its output register; one pending transaction
// waits behind it and samples stalls until the output moves.
//
// Depends on rm_pkg, rm_if, rm_chain, rm_cell.
module running_median #(
  parameter int CAPACITY = 1024
) (
  input  logic          clk,
  input  logic          rst,
  rm_sample_if.sink     samples,
  rm_result_if.source   results
);

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int L_DEPTH = (CAPACITY + 1) / 2;
  localparam int R_DEPTH = CAPACITY / 2;
  localparam int MED_W   = rm_pkg::MEDIAN_W;
  localparam int OCNT_W  = rm_pkg::COUNT_W;

  // Two sorted halves around the median: the lower half descends from its head
  // (head = largest low value), the upper half ascends (head = smallest high
  // value). The lower half holds ceil(count/2) entries, the upper floor(count/2).
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   size_lo;
  logic [CNT_W-1:0]                   size_hi;
  logic [CNT_W:0]                     count_p1;
  logic                               full;
  logic                               accept;
  logic                               pend;
  logic                               pend_drop;
  logic                               load;
  logic signed [rm_pkg::SAMPLE_W-1:0] lo_head;
  logic signed [rm_pkg::SAMPLE_W-1:0] hi_head;
  logic signed [rm_pkg::SAMPLE_W-1:0] smp;
  logic signed [MED_W-1:0]            median_next;
  rm_pkg::chain_ctrl_t                lo_ctrl;
  rm_pkg::chain_ctrl_t                hi_ctrl;

  logic                               out_valid;
  logic signed [MED_W-1:0]            out_median;
  logic [OCNT_W-1:0]                  out_count;
  logic                               out_drop;

  assign smp      = samples.sample;
  assign count_p1 = {1'b0, count} + 1'b1;
  assign size_lo  = count_p1[CNT_W:1];
  assign size_hi  = count >> 1;
  assign full     = (count >= CNT_W'(CAPACITY));

  // Advance the output register when a result waits and the slot frees up
  assign load           = pend && (!out_valid || results.ready);
  assign samples.ready  = !pend || load;
  assign accept         = samples.valid && samples.ready;

  // Route the sample so the halves stay balanced
  always_comb begin
    lo_ctrl.op       = rm_pkg::OP_HOLD;
    lo_ctrl.sample   = smp;
    lo_ctrl.push_val = hi_head;
    hi_ctrl.op       = rm_pkg::OP_HOLD;
    hi_ctrl.sample   = smp;
    hi_ctrl.push_val = lo_head;
    if (accept && !full) begin
      if (!count[0]) begin
        // Even count: lower half grows
        if ((count != '0) && (smp > hi_head)) begin
          lo_ctrl.op = rm_pkg::OP_PUSH;
          hi_ctrl.op = rm_pkg::OP_POP_INSERT;
        end else begin
          lo_ctrl.op = rm_pkg::OP_INSERT;
        end
      end else begin
        // Odd count: upper half grows
        if (smp >= lo_head) begin
          hi_ctrl.op = rm_pkg::OP_INSERT;
        end else begin
          hi_ctrl.op = rm_pkg::OP_PUSH;
          lo_ctrl.op = rm_pkg::OP_POP_INSERT;
        end
      end
    end
  end

  rm_chain #(
    .DEPTH   (L_DEPTH),
    .CNT_W   (CNT_W),
    .DESCEND (1'b1)
  ) u_lo (
    .clk        (clk),
    .ctrl       (lo_ctrl),
    .size       (size_lo),
    .head_value (lo_head)
  );

  rm_chain #(
    .DEPTH   (R_DEPTH),
    .CNT_W   (CNT_W),
    .DESCEND (1'b0)
  ) u_hi (
    .clk        (clk),
    .ctrl       (hi_ctrl),
    .size       (size_hi),
    .head_value (hi_head)
  );

  // Odd count: twice the middle; even: sum of the two heads
  always_comb begin
    if (count[0]) begin
      median_next = {lo_head, 1'b0};
    end else begin
      median_next = MED_W'(lo_head) + MED_W'(hi_head);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && !full) begin
        count <= count + 1'b1;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_drop <= full;
    end
    if (load) begin
      out_median <= median_next;
      out_count  <= OCNT_W'(count);
      out_drop   <= pend_drop;
    end
  end

  assign results.valid          = out_valid;
  assign results.median_doubled = out_median;
  assign results.sample_count   = out_count;
  assign results.dropped        = out_drop;

  // Store never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // Dropped sample leaves the store unchanged
  a_drop_hold: assert property (@(posedge clk) disable iff (rst)
    accept && full |=> count == $past(count))
    else $error("count moved on a dropped sample");

  // Stored sample grows the count by one
  a_store_inc: assert property (@(posedge clk) disable iff (rst)
    accept && !full |=> count == $past(count) + 1'b1)
    else $error("count did not advance on a stored sample");

  // A drop is only reported with a full store
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.dropped |-> results.sample_count == OCNT_W'(CAPACITY))
    else $error("drop flagged below capacity");

endmodule

### hw/rtl/rm_cell.sv
// rm_cell: one storage cell of a sorted chain.
// Depends on rm_pkg for the control and link structs.
module rm_cell #(
  parameter bit DESCEND = 1'b0
) (
  input  logic                 clk,
  input  rm_pkg::chain_ctrl_t  ctrl,
  input  logic                 occ,
  input  logic                 head,
  input  rm_pkg::cell_link_t   prev,
  input  rm_pkg::cell_link_t   next,
  output rm_pkg::cell_link_t   link
);

  logic signed [rm_pkg::SAMPLE_W-1:0] value;
  logic signed [rm_pkg::SAMPLE_W-1:0] value_next;
  logic signed [rm_pkg::SAMPLE_W-1:0] smp;
  logic                               ahead;

  assign smp = ctrl.sample;

  // Stays ahead of the sample: ties keep the held value first
  assign ahead = occ && (DESCEND ? (value >= smp) : (value <= smp));

  assign link.value = value;
  assign link.ahead = ahead;

  always_comb begin
    case (ctrl.op)
      rm_pkg::OP_INSERT: begin
        if (ahead) begin
          value_next = value;
        end else if (prev.ahead) begin
          value_next = smp;
        end else begin
          value_next = prev.value;
        end
      end
      rm_pkg::OP_PUSH: begin
        value_next = prev.value;
      end
      rm_pkg::OP_POP_INSERT: begin
        if (next.ahead) begin
          value_next = next.value;
        end else if (head || ahead) begin
          value_next = smp;
        end else begin
          value_next = value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### hw/rtl/rm_chain.sv
// rm_chain: a row of rm_cell kept sorted, extreme value at cell 0.
// Depends on rm_pkg and rm_cell.
module rm_chain #(
  parameter int DEPTH   = 512,
  parameter int CNT_W   = 11,
  parameter bit DESCEND = 1'b0
) (
  input  logic                               clk,
  input  rm_pkg::chain_ctrl_t                ctrl,
  input  logic [CNT_W-1:0]                   size,
  output logic signed [rm_pkg::SAMPLE_W-1:0] head_value
);

  rm_pkg::cell_link_t links [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      rm_pkg::cell_link_t prev_link;
      rm_pkg::cell_link_t next_link;
      logic               occ;

      assign occ = (size > CNT_W'(i));

      if (i == 0) begin : g_head
        // Head sees the pushed value; an insert lands here when it beats the head
        assign prev_link.value = ctrl.push_val;
        assign prev_link.ahead = 1'b1;
      end else begin : g_body
        assign prev_link = links[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign next_link.value = '0;
        assign next_link.ahead = 1'b0;
      end else begin : g_mid
        assign next_link = links[i+1];
      end

      rm_cell #(
        .DESCEND (DESCEND)
      ) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .occ  (occ),
        .head (i == 0),
        .prev (prev_link),
        .next (next_link),
        .link (links[i])
      );
    end
  endgenerate

  assign head_value = links[0].value;

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for the running median block.
// Drives samples through rm_sample_if and checks every transaction on rm_result_if.
// Depends on rm_pkg, rm_if and running_median.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = rm_pkg::SAMPLE_W;
  localparam int MEDIAN_W = rm_pkg::MEDIAN_W;
  localparam int COUNT_W  = rm_pkg::COUNT_W;

  // The store depth matches the block's default, so the 11-bit count reaches the
  // capacity and the samples beyond it exercise the full-store drop.
  localparam int STORE_DEPTH  = 1024;
  localparam int N_RANDOM     = 1836;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic        [COUNT_W-1:0]  sample_count;
    logic                       dropped;
  } median_result_t;

  // One row of the opening sequence. Rows with known_result set carry an
  // expectation typed in by hand; the others go through the predictor.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known_result;
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic        [COUNT_W-1:0]  sample_count;
    logic                       dropped;
  } opening_row_t;

  localparam int N_OPEN = 14;

  opening_row_t opening_rows [N_OPEN] = '{
    // most negative sample alone: doubled median is -2^32
    '{32'h8000_0000, 1'b1, 33'h1_0000_0000, 11'd1, 1'b0},
    // both extremes: their sum is -1
    '{32'h7FFF_FFFF, 1'b1, 33'h1_FFFF_FFFF, 11'd2, 1'b0},
    // largest sample in the middle: doubled median is the top of the range
    '{32'h7FFF_FFFF, 1'b1, 33'h0_FFFF_FFFE, 11'd3, 1'b0},
    // even count, middle pair is -1 and the largest sample
    '{32'hFFFF_FFFF, 1'b1, 33'h0_7FFF_FFFE, 11'd4, 1'b0},
    // zero lands exactly in the middle
    '{32'h0000_0000, 1'b1, 33'h0_0000_0000, 11'd5, 1'b0},
    // equal samples, alternating bit patterns, values next to the extremes
    '{32'h0000_0000, 1'b0, '0, '0, 1'b0},
    '{32'h8000_0000, 1'b0, '0, '0, 1'b0},
    '{32'h5555_5555, 1'b0, '0, '0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0},
    '{32'h0000_0001, 1'b0, '0, '0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0},
    '{32'h8000_0001, 1'b0, '0, '0, 1'b0},
    '{32'h7FFF_FFFE, 1'b0, '0, '0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  rm_sample_if sample_ch ();
  rm_result_if result_ch ();

  running_median #(
    .CAPACITY (STORE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: a sorted copy of every sample the block should hold.
  logic signed [SAMPLE_W-1:0] held_samples [$];
  median_result_t             pending_medians [$];

  int accepted_count  = 0;
  int checked_count   = 0;
  int dropped_seen    = 0;
  int fail_count      = 0;
  int cycle_count     = 0;
  int result_stall    = 0;

  // Insert one sample into the sorted copy (after any equal values), or drop
  // it on a full store, then form twice the median of what is held.
  function automatic median_result_t advance_median(input logic signed [SAMPLE_W-1:0] s);
    median_result_t             r;
    int                         pos;
    int                         n;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    r.dropped = (held_samples.size() >= STORE_DEPTH);
    if (!r.dropped) begin
      pos = held_samples.size();
      while (pos > 0 && held_samples[pos-1] > s) pos--;
      held_samples.insert(pos, s);
    end
    n = held_samples.size();
    if (n % 2 == 1) begin
      lo = held_samples[n/2];
      r.median_doubled = {lo, 1'b0};
    end else begin
      lo = held_samples[n/2-1];
      hi = held_samples[n/2];
      // widen both by one sign bit so the sum cannot wrap
      r.median_doubled = $signed({lo[SAMPLE_W-1], lo}) + $signed({hi[SAMPLE_W-1], hi});
    end
    r.sample_count = COUNT_W'(n);
    return r;
  endfunction

  // Mix of full-range values, a tight cluster around zero (lots of equal
  // and neighboring samples near the median) and the extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return SAMPLE_W'($urandom_range(0, 200)) - 32'sd100;
      default: return $urandom();
    endcase
  endfunction

  // Every fourth stretch of 128 transactions runs with no idling at all.
  function automatic bit calm_stretch(input int n);
    return ((n / 128) % 4) == 3;
  endfunction

  // Compare one result transaction against the oldest expectation.
  task automatic check_result();
    median_result_t want;
    if (pending_medians.size() == 0) begin
      $error("unexpected result: median_doubled %0d, sample_count %0d, dropped %0d",
             result_ch.median_doubled, result_ch.sample_count, result_ch.dropped);
      fail_count++;
    end else begin
      want = pending_medians.pop_front();
      if (result_ch.median_doubled !== want.median_doubled) begin
        $error("median_doubled: expected %0d, got %0d",
               want.median_doubled, result_ch.median_doubled);
        fail_count++;
      end
      if (result_ch.sample_count !== want.sample_count) begin
        $error("sample_count: expected %0d, got %0d",
               want.sample_count, result_ch.sample_count);
        fail_count++;
      end
      if (result_ch.dropped !== want.dropped) begin
        $error("dropped: expected %0d, got %0d", want.dropped, result_ch.dropped);
        fail_count++;
      end
      if (want.dropped) dropped_seen++;
    end
    checked_count++;
  endtask

  // Monitor: sample both channels at the rising edge. Results are checked
  // before a new sample is predicted; the two cannot belong to the same
  // transaction since the block registers each result after accepting its sample.
  always @(posedge clk) begin
    median_result_t predicted;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        check_result();
        // draw the stall that the next result will see
        result_stall = calm_stretch(checked_count) ? 0 : $urandom_range(0, 6);
      end
      if (sample_ch.valid && sample_ch.ready) begin
        predicted = advance_median(sample_ch.sample);
        // hand-typed rows replace the prediction but still advance the state
        if (accepted_count < N_OPEN && opening_rows[accepted_count].known_result) begin
          predicted.median_doubled = opening_rows[accepted_count].median_doubled;
          predicted.sample_count   = opening_rows[accepted_count].sample_count;
          predicted.dropped        = opening_rows[accepted_count].dropped;
        end
        pending_medians.insert(pending_medians.size(), predicted);
        accepted_count++;
      end
    end
  end

  // Hard stop: the slowest legal run is far below this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: hold ready low for the drawn number of cycles after each
  // transaction, independent of valid, so stalls land on every phase.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (result_stall > 0) begin
        result_ch.ready <= 1'b0;
        result_stall--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Sample side: reset, the opening rows, then the random stream. All
  // changes happen at the falling edge; acceptance is observed at the rising.
  initial begin
    int                         total;
    int                         gap;
    logic signed [SAMPLE_W-1:0] next_sample;
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    total = N_OPEN + N_RANDOM;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int idx = 0; idx < total; idx++) begin
      next_sample = (idx < N_OPEN) ? opening_rows[idx].sample : pick_sample();
      gap = calm_stretch(idx) ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (gap > 0) begin
        // drop valid for the gap, then present the next transaction
        sample_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      sample_ch.valid  <= 1'b1;
      sample_ch.sample <= next_sample;
      // hold until accepted
      do @(posedge clk); while (!sample_ch.ready);
    end
    @(negedge clk);
    sample_ch.valid <= 1'b0;

    // drain, then keep clocking through the tail so any stray result shows
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (%0d dropped on a full store of %0d entries).",
             accepted_count, dropped_seen, STORE_DEPTH);
    $display("Checked %0d result transactions, %0d mismatches, %0d still outstanding.",
             checked_count, fail_count, pending_medians.size());
    if (fail_count == 0 && pending_medians.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
